// ===== hdl/grot_pkg.sv =====
// grot_pkg: shared types, sizes and arithmetic helpers of the givens rotation unit
`default_nettype none
package grot_pkg;

   localparam int FRAC_BITS_DEF = 30;
   localparam int DATA_W        = 32;
   localparam int PROD_W        = 64;
   localparam int SUM_W         = 66;
   localparam int WIDE_W        = 128;
   localparam int SRCH_STEPS    = 32;

   localparam logic MODE_APPLY = 1'b0;
   localparam logic MODE_GEN   = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] q;
      logic [WIDE_W-1:0] p;
      logic [WIDE_W-1:0] w;
      logic              done;
   } srch_type;

   typedef struct packed {
      logic                     mode;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] c;
      logic signed [DATA_W-1:0] s;
      logic                     neg_c;
      logic                     neg_s;
      logic                     y_zero;
      logic [PROD_W-1:0]        ssum;
      logic [WIDE_W-1:0]        rhs_x;
      logic [WIDE_W-1:0]        rhs_y;
      logic                     huge_x;
      logic                     huge_y;
      logic                     nz_x;
      logic                     nz_y;
   } ctx_type;

   // one bit of the factor search: p tracks (2q-1)^2*S, w tracks (2q-1)*S
   function automatic srch_type srch_step(srch_type st, logic [PROD_W-1:0] ssum,
                                          logic [WIDE_W-1:0] rhs, logic huge,
                                          logic nz, int b);
      logic [WIDE_W-1:0] s_w;
      logic [WIDE_W-1:0] cand;
      logic              fit;
      srch_type          nx;
      s_w  = WIDE_W'(ssum);
      cand = st.p + (st.w << (b + 2)) + (s_w << (2 * b + 2));
      fit  = nz && (huge || (cand <= rhs));
      nx   = st;
      if (!st.done && fit) begin
         nx.q = st.q | (DATA_W'(1) << b);
         nx.p = cand;
         nx.w = st.w + (s_w << (b + 1));
         if (b == DATA_W - 1) begin
            nx.done = 1'b1;
         end
      end
      return nx;
   endfunction

   function automatic logic [DATA_W-1:0] sign_factor(logic [DATA_W-1:0] mag, logic neg);
      logic [DATA_W-1:0] r;
      if (neg) begin
         r = -mag;
      end else if (mag[DATA_W-1]) begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r = mag;
      end
      return r;
   endfunction

   // round half up, then saturate
   function automatic logic [DATA_W-1:0] sat_rnd(logic signed [PROD_W-1:0] a,
                                                 logic signed [PROD_W-1:0] b,
                                                 logic signed [SUM_W-1:0] half, int f);
      logic signed [SUM_W-1:0] t;
      logic [DATA_W-1:0]       r;
      t = (SUM_W'(a) + SUM_W'(b) + half) >>> f;
      if (t > SUM_W'(64'sh7FFF_FFFF)) begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (t < -SUM_W'(64'sh8000_0000)) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = t[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/givens_rotation_unit.sv =====
// givens_rotation_unit: pipelined givens rotation apply and generate
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   mode, x_in, y_in, cos_in, sin_in
//   rsp       out         rsp_valid / rsp_ready   x_out, y_out, cos_out, sin_out
//
// one transfer in per cycle while rsp is not stalled; stages: input, square, sum, 32 search
// steps (one factor bit each, both factors side by side), factor, multiply, round
// the bit search sets the depth; each step is one wide add and compare
// synchronous reset empties every stage; no clearing pass
// a stalled rsp holds the whole pipeline, req_ready follows it
`default_nettype none
module givens_rotation_unit #(
   parameter int FRAC_BITS = grot_pkg::FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic signed [31:0] req_x_in,
   input  wire logic signed [31:0] req_y_in,
   input  wire logic signed [31:0] req_cos_in,
   input  wire logic signed [31:0] req_sin_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_x_out,
   output logic signed [31:0] rsp_y_out,
   output logic signed [31:0] rsp_cos_out,
   output logic signed [31:0] rsp_sin_out
);

   localparam int STEPS  = grot_pkg::SRCH_STEPS;
   localparam int DW     = grot_pkg::DATA_W;
   localparam int PW     = grot_pkg::PROD_W;
   localparam int WW     = grot_pkg::WIDE_W;
   localparam int RSH    = 2 * FRAC_BITS + 2;
   localparam int HUGE_T = WW - 2 - 2 * FRAC_BITS;
   localparam logic [DW-1:0] ONE_Q = (FRAC_BITS >= DW - 1) ?
                                     {1'b0, {(DW-1){1'b1}}} : DW'(64'd1 << FRAC_BITS);
   localparam logic signed [grot_pkg::SUM_W-1:0] HALF =
      grot_pkg::SUM_W'(1) <<< (FRAC_BITS - 1);

   logic en;

   // input stage
   logic              vld_a_ff;
   logic              mode_a_ff;
   logic signed [DW-1:0] x_a_ff, y_a_ff, c_a_ff, s_a_ff;
   logic [DW-1:0]     mx_a_ff, my_a_ff;
   logic [DW-1:0]     mx_a_in, my_a_in;

   // square stage
   logic              vld_b_ff;
   grot_pkg::ctx_type ctx_b_ff, ctx_b_in;
   logic [PW-1:0]     m2x_b_ff, m2y_b_ff, m2x_b_in, m2y_b_in;
   logic              lneg;

   // search stages, index 0 is the sum stage
   logic [STEPS:0]     vld_s_ff;
   grot_pkg::ctx_type  ctx_s_ff [0:STEPS];
   grot_pkg::srch_type sx_ff    [0:STEPS];
   grot_pkg::srch_type sy_ff    [0:STEPS];
   grot_pkg::srch_type sx_in    [0:STEPS];
   grot_pkg::srch_type sy_in    [0:STEPS];
   grot_pkg::ctx_type  ctx_c_in;

   // factor, multiply and output stages
   logic              vld_e_ff, vld_m_ff, vld_o_ff;
   logic              mode_e_ff, yz_e_ff, mode_m_ff, yz_m_ff, mode_o_ff, yz_o_ff;
   logic signed [DW-1:0] x_e_ff, y_e_ff, c_e_ff, s_e_ff, c_e_in, s_e_in;
   logic signed [DW-1:0] c_m_ff, s_m_ff;
   logic signed [PW-1:0] pcx_m_ff, psy_m_ff, pcy_m_ff, psx_m_ff;
   logic signed [PW-1:0] pcx_m_in, psy_m_in, pcy_m_in, psx_m_in;
   logic [DW-1:0]     xo_ff, yo_ff, co_ff, so_ff;

   assign en        = !vld_o_ff || rsp_ready;
   assign req_ready = en;

   assign mx_a_in = req_x_in[DW-1] ? DW'(-req_x_in) : req_x_in;
   assign my_a_in = req_y_in[DW-1] ? DW'(-req_y_in) : req_y_in;

   assign m2x_b_in = PW'(mx_a_ff) * PW'(mx_a_ff);
   assign m2y_b_in = PW'(my_a_ff) * PW'(my_a_ff);
   assign lneg     = (my_a_ff > mx_a_ff) ? y_a_ff[DW-1] : x_a_ff[DW-1];

   always_comb begin
      ctx_b_in        = '0;
      ctx_b_in.mode   = mode_a_ff;
      ctx_b_in.x      = x_a_ff;
      ctx_b_in.y      = y_a_ff;
      ctx_b_in.c      = c_a_ff;
      ctx_b_in.s      = s_a_ff;
      ctx_b_in.neg_c  = (x_a_ff[DW-1] != lneg) && (mx_a_ff != '0);
      ctx_b_in.neg_s  = (y_a_ff[DW-1] != lneg);
      ctx_b_in.y_zero = (y_a_ff == '0);
      ctx_b_in.nz_x   = (mx_a_ff != '0);
      ctx_b_in.nz_y   = (my_a_ff != '0);
   end

   always_comb begin
      ctx_c_in        = ctx_b_ff;
      ctx_c_in.ssum   = m2x_b_ff + m2y_b_ff;
      ctx_c_in.rhs_x  = WW'(m2x_b_ff) << RSH;
      ctx_c_in.rhs_y  = WW'(m2y_b_ff) << RSH;
      ctx_c_in.huge_x = |(WW'(m2x_b_ff) >> HUGE_T);
      ctx_c_in.huge_y = |(WW'(m2y_b_ff) >> HUGE_T);
      sx_in[0].q      = '0;
      sx_in[0].p      = WW'(ctx_c_in.ssum);
      sx_in[0].w      = -WW'(ctx_c_in.ssum);
      sx_in[0].done   = 1'b0;
      sy_in[0]        = sx_in[0];
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_srch
      assign sx_in[k+1] = grot_pkg::srch_step(sx_ff[k], ctx_s_ff[k].ssum, ctx_s_ff[k].rhs_x,
                                              ctx_s_ff[k].huge_x, ctx_s_ff[k].nz_x,
                                              STEPS - 1 - k);
      assign sy_in[k+1] = grot_pkg::srch_step(sy_ff[k], ctx_s_ff[k].ssum, ctx_s_ff[k].rhs_y,
                                              ctx_s_ff[k].huge_y, ctx_s_ff[k].nz_y,
                                              STEPS - 1 - k);
   end

   always_comb begin
      c_e_in = ctx_s_ff[STEPS].c;
      s_e_in = ctx_s_ff[STEPS].s;
      if (ctx_s_ff[STEPS].mode == grot_pkg::MODE_GEN) begin
         if (ctx_s_ff[STEPS].y_zero) begin
            c_e_in = ONE_Q;
            s_e_in = '0;
         end else begin
            c_e_in = grot_pkg::sign_factor(sx_ff[STEPS].q, ctx_s_ff[STEPS].neg_c);
            s_e_in = grot_pkg::sign_factor(sy_ff[STEPS].q, ctx_s_ff[STEPS].neg_s);
         end
      end
   end

   assign pcx_m_in = PW'(c_e_ff) * PW'(x_e_ff);
   assign psy_m_in = PW'(s_e_ff) * PW'(y_e_ff);
   assign pcy_m_in = PW'(c_e_ff) * PW'(y_e_ff);
   assign psx_m_in = PW'(s_e_ff) * PW'(x_e_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_s_ff <= '0;
         vld_e_ff <= 1'b0;
         vld_m_ff <= 1'b0;
         vld_o_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= req_valid;
         vld_b_ff <= vld_a_ff;
         vld_s_ff <= {vld_s_ff[STEPS-1:0], vld_b_ff};
         vld_e_ff <= vld_s_ff[STEPS];
         vld_m_ff <= vld_e_ff;
         vld_o_ff <= vld_m_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode_a_ff <= req_mode;
         x_a_ff    <= req_x_in;
         y_a_ff    <= req_y_in;
         c_a_ff    <= req_cos_in;
         s_a_ff    <= req_sin_in;
         mx_a_ff   <= mx_a_in;
         my_a_ff   <= my_a_in;
         ctx_b_ff  <= ctx_b_in;
         m2x_b_ff  <= m2x_b_in;
         m2y_b_ff  <= m2y_b_in;
         ctx_s_ff[0] <= ctx_c_in;
         for (int k = 0; k <= STEPS; k++) begin
            sx_ff[k] <= sx_in[k];
            sy_ff[k] <= sy_in[k];
         end
         for (int k = 1; k <= STEPS; k++) begin
            ctx_s_ff[k] <= ctx_s_ff[k-1];
         end
         mode_e_ff <= ctx_s_ff[STEPS].mode;
         yz_e_ff   <= ctx_s_ff[STEPS].y_zero;
         x_e_ff    <= ctx_s_ff[STEPS].x;
         y_e_ff    <= ctx_s_ff[STEPS].y;
         c_e_ff    <= c_e_in;
         s_e_ff    <= s_e_in;
         mode_m_ff <= mode_e_ff;
         yz_m_ff   <= yz_e_ff;
         c_m_ff    <= c_e_ff;
         s_m_ff    <= s_e_ff;
         pcx_m_ff  <= pcx_m_in;
         psy_m_ff  <= psy_m_in;
         pcy_m_ff  <= pcy_m_in;
         psx_m_ff  <= psx_m_in;
         mode_o_ff <= mode_m_ff;
         yz_o_ff   <= yz_m_ff;
         xo_ff     <= grot_pkg::sat_rnd(pcx_m_ff, psy_m_ff, HALF, FRAC_BITS);
         yo_ff     <= grot_pkg::sat_rnd(pcy_m_ff, -psx_m_ff, HALF, FRAC_BITS);
         co_ff     <= c_m_ff;
         so_ff     <= s_m_ff;
      end
   end

   assign rsp_valid   = vld_o_ff;
   assign rsp_x_out   = xo_ff;
   assign rsp_y_out   = yo_ff;
   assign rsp_cos_out = co_ff;
   assign rsp_sin_out = so_ff;

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("req taken while rsp stalled");

   a_reset_empties: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid straight after reset");

   a_zero_y_sine: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (mode_o_ff == grot_pkg::MODE_GEN) && yz_o_ff) |-> (rsp_sin_out == '0))
      else $error("generated sine not zero for zero y");

   a_cap_alone: assert property (@(posedge clock) disable iff (reset)
      (vld_s_ff[STEPS] && sx_ff[STEPS].done) |-> (sx_ff[STEPS].q == {1'b1, {(DW-1){1'b0}}}))
      else $error("capped factor picked up lower bits");

endmodule
`default_nettype wire
